@@ rtl/core/wdd_pkg.sv @@
// Package for the windowed drift detector: sequencer state type, status codes,
// register indexes and fixed-point constants. No dependencies.
package wdd_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_DIV1,
        S_UPD,
        S_MULP,
        S_DIV2,
        S_SQINIT,
        S_SQRT,
        S_LIMD,
        S_LIMW,
        S_DEC,
        S_WSUB,
        S_WADD,
        S_WAIT,
        S_MSUB,
        S_MADD,
        S_OUT
    } wdd_state_t;

    localparam logic [1:0] STATUS_NORMAL = 2'd0;
    localparam logic [1:0] STATUS_WARN   = 2'd1;
    localparam logic [1:0] STATUS_DRIFT  = 2'd2;

    localparam logic [1:0] REG_WARN_FACTOR  = 2'd0;
    localparam logic [1:0] REG_DRIFT_FACTOR = 2'd1;

    localparam logic [15:0] WARN_FACTOR_RST  = 16'd8192;
    localparam logic [15:0] DRIFT_FACTOR_RST = 16'd12288;

    localparam int          RATE_W    = 17;
    localparam int          PS_W      = 18;
    localparam int          LIM_W     = 22;
    localparam int          NUM_W     = 33;
    localparam int          ROOT_W    = 34;
    localparam int          DIV1_STEPS = 17;
    localparam int          DIV2_STEPS = 33;
    localparam int          SQRT_STEPS = 17;

    localparam logic [RATE_W-1:0] ONE_Q16     = 17'h10000;
    localparam logic [RATE_W-1:0] ALL_ONES_17 = 17'h1FFFF;
    localparam logic [PS_W-1:0]   ALL_ONES_18 = 18'h3FFFF;

endpackage

@@ rtl/core/wdd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the sample window banks; no dependencies.
module wdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/windowed_drift_detector.sv @@
// Windowed drift detector: one status word per sample word, via a shared ALU sequencer.
// The shift-add multiply is skipped when the main window is empty; a warning push adds the
// warning-bank steps; a busy output register holds the result step. One word in flight; the
// next is taken in the cycle after the result loads. The 17- and 33-step divider and the
// 17-step square root share one adder.
// Reset (rst_n low, async) resets all registers; the bank RAMs keep their contents. Depends on wdd_pkg and wdd_ram.
module windowed_drift_detector #(
    parameter int WINDOW_DEPTH = 1024,
    parameter int COUNT_CAP    = 1000,
    parameter int WARMUP_COUNT = 30,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        was_error,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import wdd_pkg::*;

    localparam int PW    = $clog2(WINDOW_DEPTH);
    localparam int FW    = $clog2(WINDOW_DEPTH + 1);
    localparam int CW    = $clog2(COUNT_CAP + 1);
    localparam int SUM_W = SAMPLE_WIDTH + PW + 1;
    localparam int AW    = (SUM_W + 2 > 36) ? SUM_W + 2 : 36;
    localparam int NMAX  = (FW > DIV2_STEPS) ? FW : DIV2_STEPS;
    localparam int KW    = $clog2(NMAX + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    wdd_state_t              state_reg, state_next;
    logic [SAMPLE_WIDTH-1:0] x_reg, x_next;
    logic [AW-1:0]           acc_reg, acc_next;
    logic [FW-1:0]           fsh_reg, fsh_next;
    logic [KW-1:0]           cnt_reg, cnt_next;
    logic                    err_reg, err_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [NUM_W-1:0]        quo_reg, quo_next;
    logic [CW-1:0]           rem_reg, rem_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [ROOT_W-1:0]       sqbit_reg, sqbit_next;
    logic [LIM_W-1:0]        limd_reg, limd_next;
    logic [LIM_W-1:0]        limw_reg, limw_next;
    logic                    wpush_reg, wpush_next;
    logic [1:0]              stat_reg, stat_next;
    logic                    main_is_b_reg, main_is_b_next;
    logic [SUM_W-1:0]        main_sum_reg, main_sum_next;
    logic [SUM_W-1:0]        warn_sum_reg, warn_sum_next;
    logic [FW-1:0]           main_fill_reg, main_fill_next;
    logic [FW-1:0]           warn_fill_reg, warn_fill_next;
    logic [PW-1:0]           main_ptr_reg, main_ptr_next;
    logic [PW-1:0]           warn_ptr_reg, warn_ptr_next;
    logic [RATE_W-1:0]       rate_reg, rate_next;
    logic [RATE_W-1:0]       dev_reg, dev_next;
    logic [RATE_W-1:0]       min_rate_reg, min_rate_next;
    logic [RATE_W-1:0]       min_dev_reg, min_dev_next;
    logic [PS_W-1:0]         min_ps_reg, min_ps_next;
    logic [CW-1:0]           step_reg, step_next;
    logic                    restart_reg, restart_next;
    logic [15:0]             warn_f_reg, warn_f_next;
    logic [15:0]             drift_f_reg, drift_f_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              out_status_reg, out_status_next;
    logic                    out_err_reg, out_err_next;

    // ------------------------------------------------------------------
    // Shared datapath pieces
    // ------------------------------------------------------------------
    logic [SAMPLE_WIDTH+31:0] sample_ext;
    logic [AW-1:0]            alu_a, alu_b, alu_res;
    logic                     alu_sub, alu_ge;
    logic [RATE_W-1:0]        mul_a, mul_b;
    logic [2*RATE_W-1:0]      mul_p;
    logic [AW-1:0]            x_wide, main_sum_wide, warn_sum_wide;
    logic [AW-1:0]            main_old_wide, warn_old_wide;
    logic [CW:0]              rem_shift;
    logic [ROOT_W-1:0]        root_trial;
    logic [RATE_W-1:0]        one_minus_rate;
    logic [CW-1:0]            step_adv;
    logic [PS_W-1:0]          ps;
    logic                     past_warmup;
    logic [PW-1:0]            main_nx, warn_nx;
    logic                     main_full, warn_full;

    // Window banks
    logic                    we_a, we_b;
    logic [PW-1:0]           wr_addr, raddr_a, raddr_b;
    logic [SAMPLE_WIDTH-1:0] rd_a, rd_b, main_old, warn_old;

    wdd_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(WINDOW_DEPTH)) u_bank_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (wr_addr),
        .wdata (x_reg),
        .raddr (raddr_a),
        .rdata (rd_a)
    );

    wdd_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(WINDOW_DEPTH)) u_bank_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (wr_addr),
        .wdata (x_reg),
        .raddr (raddr_b),
        .rdata (rd_b)
    );

    // Slot after each write pointer; reads there stay valid while the pointer holds,
    // so the oldest sample is ready whenever a full window evicts it.
    assign main_nx = (main_ptr_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : main_ptr_reg + 1'b1;
    assign warn_nx = (warn_ptr_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : warn_ptr_reg + 1'b1;
    assign raddr_a = main_is_b_reg ? warn_nx : main_nx;
    assign raddr_b = main_is_b_reg ? main_nx : warn_nx;
    assign main_old = main_is_b_reg ? rd_b : rd_a;
    assign warn_old = main_is_b_reg ? rd_a : rd_b;
    assign main_full = (main_fill_reg == FW'(WINDOW_DEPTH));
    assign warn_full = (warn_fill_reg == FW'(WINDOW_DEPTH));

    // Write the warning bank in S_WADD and the main bank in S_MADD
    assign wr_addr = (state_reg == S_WADD) ? warn_nx : main_nx;
    assign we_a = ((state_reg == S_WADD) && main_is_b_reg)
               || ((state_reg == S_MADD) && !main_is_b_reg);
    assign we_b = ((state_reg == S_WADD) && !main_is_b_reg)
               || ((state_reg == S_MADD) && main_is_b_reg);

    // Sign handling: the sample is two's complement over its low SAMPLE_WIDTH bits
    assign sample_ext    = {{SAMPLE_WIDTH{1'b0}}, sample};
    assign x_wide        = {{(AW-SAMPLE_WIDTH){x_reg[SAMPLE_WIDTH-1]}}, x_reg};
    assign main_sum_wide = {{(AW-SUM_W){main_sum_reg[SUM_W-1]}}, main_sum_reg};
    assign warn_sum_wide = {{(AW-SUM_W){warn_sum_reg[SUM_W-1]}}, warn_sum_reg};
    assign main_old_wide = {{(AW-SAMPLE_WIDTH){main_old[SAMPLE_WIDTH-1]}}, main_old};
    assign warn_old_wide = {{(AW-SAMPLE_WIDTH){warn_old[SAMPLE_WIDTH-1]}}, warn_old};

    // The one adder/subtractor, shared by the multiply, compare, divide, update, square-root and window steps
    assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);
    assign alu_ge  = ~alu_res[AW-1];

    // The one multiplier: p*(1-p), then the two limit products
    assign mul_p = mul_a * mul_b;

    assign rem_shift      = {rem_reg, num_reg[NUM_W-1]};
    assign root_trial     = root_reg | sqbit_reg;
    assign one_minus_rate = ONE_Q16 - rate_reg;
    assign step_adv       = (32'(step_reg) < COUNT_CAP) ? step_reg + 1'b1 : CW'(COUNT_CAP);
    assign ps             = {1'b0, rate_reg} + {1'b0, dev_reg};
    assign past_warmup    = (32'(step_adv) > WARMUP_COUNT);

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign was_error = out_err_reg;

    // ------------------------------------------------------------------
    // Operand selection for the shared units
    // ------------------------------------------------------------------
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            S_MUL:
            begin
                alu_a = {acc_reg[AW-2:0], 1'b0};
                alu_b = fsh_reg[FW-1] ? x_wide : '0;
            end
            S_CMP:
            begin
                alu_a   = main_sum_wide;
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            S_DIV1, S_DIV2:
            begin
                alu_a   = {{(AW-CW-1){1'b0}}, rem_shift};
                alu_b   = {{(AW-CW){1'b0}}, step_reg};
                alu_sub = 1'b1;
            end
            S_UPD:
            begin
                alu_a   = {{(AW-RATE_W){1'b0}}, rate_reg};
                alu_b   = {{(AW-RATE_W){1'b0}}, quo_reg[RATE_W-1:0]};
                alu_sub = err_reg;
            end
            S_SQRT:
            begin
                alu_a   = acc_reg;
                alu_b   = {{(AW-ROOT_W){1'b0}}, root_trial};
                alu_sub = 1'b1;
            end
            S_WSUB:
            begin
                alu_a   = warn_sum_wide;
                alu_b   = warn_old_wide;
                alu_sub = 1'b1;
            end
            S_WADD:
            begin
                alu_a = warn_sum_wide;
                alu_b = x_wide;
            end
            S_MSUB:
            begin
                alu_a   = main_sum_wide;
                alu_b   = main_old_wide;
                alu_sub = 1'b1;
            end
            S_MADD:
            begin
                alu_a = main_sum_wide;
                alu_b = x_wide;
            end
            S_MULP:
            begin
                mul_a = rate_reg;
                mul_b = one_minus_rate;
            end
            S_LIMD:
            begin
                mul_a = {1'b0, drift_f_reg};
                mul_b = min_dev_reg;
            end
            S_LIMW:
            begin
                mul_a = {1'b0, warn_f_reg};
                mul_b = min_dev_reg;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and register updates
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        x_next          = x_reg;
        acc_next        = acc_reg;
        fsh_next        = fsh_reg;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        num_next        = num_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        sqbit_next      = sqbit_reg;
        limd_next       = limd_reg;
        limw_next       = limw_reg;
        wpush_next      = wpush_reg;
        stat_next       = stat_reg;
        main_is_b_next  = main_is_b_reg;
        main_sum_next   = main_sum_reg;
        warn_sum_next   = warn_sum_reg;
        main_fill_next  = main_fill_reg;
        warn_fill_next  = warn_fill_reg;
        main_ptr_next   = main_ptr_reg;
        warn_ptr_next   = warn_ptr_reg;
        rate_next       = rate_reg;
        dev_next        = dev_reg;
        min_rate_next   = min_rate_reg;
        min_dev_next    = min_dev_reg;
        min_ps_next     = min_ps_reg;
        step_next       = step_reg;
        restart_next    = restart_reg;
        warn_f_next     = warn_f_reg;
        drift_f_next    = drift_f_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_err_next    = out_err_reg;

        // Drop the result word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_WARN_FACTOR:  warn_f_next  = cfg_data;
                REG_DRIFT_FACTOR: drift_f_next = cfg_data;
                default:          warn_f_next  = warn_f_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next   = sample_ext[SAMPLE_WIDTH-1:0];
                    acc_next = '0;
                    fsh_next = main_fill_reg;
                    if (main_fill_reg == '0)
                    begin
                        // Empty window: no mean, always an error
                        err_next   = 1'b1;
                        num_next   = {rate_reg, 16'b0};
                        quo_next   = '0;
                        rem_next   = '0;
                        cnt_next   = KW'(DIV1_STEPS);
                        state_next = S_DIV1;
                    end
                    else
                    begin
                        cnt_next   = KW'(FW);
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                // Shift-add x * fill, MSB of the fill first
                acc_next = alu_res;
                fsh_next = {fsh_reg[FW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == KW'(1))
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                // x <= floor(sum/fill)  iff  sum - x*fill >= 0
                err_next   = alu_ge;
                num_next   = {(alu_ge ? rate_reg : one_minus_rate), 16'b0};
                quo_next   = '0;
                rem_next   = '0;
                cnt_next   = KW'(DIV1_STEPS);
                state_next = S_DIV1;
            end
            S_DIV1, S_DIV2:
            begin
                rem_next = alu_ge ? alu_res[CW-1:0] : rem_shift[CW-1:0];
                quo_next = {quo_reg[NUM_W-2:0], alu_ge};
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == KW'(1))
                begin
                    state_next = (state_reg == S_DIV1) ? S_UPD : S_SQINIT;
                end
            end
            S_UPD:
            begin
                rate_next  = alu_res[RATE_W-1:0];
                state_next = S_MULP;
            end
            S_MULP:
            begin
                num_next   = mul_p[NUM_W-1:0];
                quo_next   = '0;
                rem_next   = '0;
                cnt_next   = KW'(DIV2_STEPS);
                state_next = S_DIV2;
            end
            S_SQINIT:
            begin
                acc_next   = {{(AW-NUM_W){1'b0}}, quo_reg};
                root_next  = '0;
                sqbit_next = ROOT_W'(1) << (2 * (SQRT_STEPS - 1));
                cnt_next   = KW'(SQRT_STEPS);
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (alu_ge)
                begin
                    acc_next  = alu_res;
                    root_next = (root_reg >> 1) | sqbit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                sqbit_next = sqbit_reg >> 2;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == KW'(1))
                begin
                    dev_next   = alu_ge ? ((root_reg[RATE_W:1]) | sqbit_reg[RATE_W-1:0])
                                        : root_reg[RATE_W:1];
                    state_next = S_LIMD;
                end
            end
            S_LIMD:
            begin
                limd_next  = {5'b0, min_rate_reg} + LIM_W'(mul_p[2*RATE_W-1:12]);
                state_next = S_LIMW;
            end
            S_LIMW:
            begin
                limw_next  = {5'b0, min_rate_reg} + LIM_W'(mul_p[2*RATE_W-1:12]);
                state_next = S_DEC;
            end
            S_DEC:
            begin
                stat_next  = STATUS_NORMAL;
                wpush_next = 1'b0;
                step_next  = step_adv;
                if (past_warmup)
                begin
                    if (ps <= min_ps_reg)
                    begin
                        min_rate_next = rate_reg;
                        min_dev_next  = dev_reg;
                        min_ps_next   = ps;
                    end
                    else if (LIM_W'(ps) >= limd_reg)
                    begin
                        // Drift: restart estimates, warning window becomes main
                        step_next      = CW'(1);
                        rate_next      = ONE_Q16;
                        dev_next       = '0;
                        min_rate_next  = ALL_ONES_17;
                        min_dev_next   = ALL_ONES_17;
                        min_ps_next    = ALL_ONES_18;
                        main_is_b_next = ~main_is_b_reg;
                        main_sum_next  = warn_sum_reg;
                        main_fill_next = warn_fill_reg;
                        main_ptr_next  = warn_ptr_reg;
                        warn_sum_next  = '0;
                        warn_fill_next = '0;
                        warn_ptr_next  = PW'(WINDOW_DEPTH - 1);
                        stat_next      = STATUS_DRIFT;
                    end
                    else if (LIM_W'(ps) >= limw_reg)
                    begin
                        if (restart_reg)
                        begin
                            warn_sum_next  = '0;
                            warn_fill_next = '0;
                            warn_ptr_next  = PW'(WINDOW_DEPTH - 1);
                            restart_next   = 1'b0;
                        end
                        wpush_next = 1'b1;
                        stat_next  = STATUS_WARN;
                    end
                    else
                    begin
                        restart_next = 1'b1;
                    end
                end
                state_next = (past_warmup && (ps > min_ps_reg) && (LIM_W'(ps) < limd_reg)
                              && (LIM_W'(ps) >= limw_reg)) ? S_WSUB : S_WAIT;
            end
            S_WSUB:
            begin
                if (warn_full)
                begin
                    warn_sum_next = alu_res[SUM_W-1:0];
                end
                state_next = S_WADD;
            end
            S_WADD:
            begin
                warn_sum_next = alu_res[SUM_W-1:0];
                warn_ptr_next = warn_nx;
                if (!warn_full)
                begin
                    warn_fill_next = warn_fill_reg + 1'b1;
                end
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                // Let the bank read settle after a swap
                state_next = S_MSUB;
            end
            S_MSUB:
            begin
                if (main_full)
                begin
                    main_sum_next = alu_res[SUM_W-1:0];
                end
                state_next = S_MADD;
            end
            S_MADD:
            begin
                main_sum_next = alu_res[SUM_W-1:0];
                main_ptr_next = main_nx;
                if (!main_full)
                begin
                    main_fill_next = main_fill_reg + 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = stat_reg;
                    out_err_next    = err_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            x_reg          <= '0;
            acc_reg        <= '0;
            fsh_reg        <= '0;
            cnt_reg        <= '0;
            err_reg        <= 1'b0;
            num_reg        <= '0;
            quo_reg        <= '0;
            rem_reg        <= '0;
            root_reg       <= '0;
            sqbit_reg      <= '0;
            limd_reg       <= '0;
            limw_reg       <= '0;
            wpush_reg      <= 1'b0;
            stat_reg       <= STATUS_NORMAL;
            main_is_b_reg  <= 1'b0;
            main_sum_reg   <= '0;
            warn_sum_reg   <= '0;
            main_fill_reg  <= '0;
            warn_fill_reg  <= '0;
            main_ptr_reg   <= PW'(WINDOW_DEPTH - 1);
            warn_ptr_reg   <= PW'(WINDOW_DEPTH - 1);
            rate_reg       <= ONE_Q16;
            dev_reg        <= '0;
            min_rate_reg   <= ALL_ONES_17;
            min_dev_reg    <= ALL_ONES_17;
            min_ps_reg     <= ALL_ONES_18;
            step_reg       <= CW'(1);
            restart_reg    <= 1'b0;
            warn_f_reg     <= WARN_FACTOR_RST;
            drift_f_reg    <= DRIFT_FACTOR_RST;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_NORMAL;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            x_reg          <= x_next;
            acc_reg        <= acc_next;
            fsh_reg        <= fsh_next;
            cnt_reg        <= cnt_next;
            err_reg        <= err_next;
            num_reg        <= num_next;
            quo_reg        <= quo_next;
            rem_reg        <= rem_next;
            root_reg       <= root_next;
            sqbit_reg      <= sqbit_next;
            limd_reg       <= limd_next;
            limw_reg       <= limw_next;
            wpush_reg      <= wpush_next;
            stat_reg       <= stat_next;
            main_is_b_reg  <= main_is_b_next;
            main_sum_reg   <= main_sum_next;
            warn_sum_reg   <= warn_sum_next;
            main_fill_reg  <= main_fill_next;
            warn_fill_reg  <= warn_fill_next;
            main_ptr_reg   <= main_ptr_next;
            warn_ptr_reg   <= warn_ptr_next;
            rate_reg       <= rate_next;
            dev_reg        <= dev_next;
            min_rate_reg   <= min_rate_next;
            min_dev_reg    <= min_dev_next;
            min_ps_reg     <= min_ps_next;
            step_reg       <= step_next;
            restart_reg    <= restart_next;
            warn_f_reg     <= warn_f_next;
            drift_f_reg    <= drift_f_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_err_reg    <= out_err_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result word raised outside the output step");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (main_fill_reg <= FW'(WINDOW_DEPTH)) && (warn_fill_reg <= FW'(WINDOW_DEPTH)))
        else $error("window fill beyond depth");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) && (32'(step_reg) <= COUNT_CAP))
        else $error("step count out of range");

    a_rate_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rate_reg <= ONE_Q16)
        else $error("error rate above one");

    a_warn_push_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WADD) |-> (stat_reg == STATUS_WARN) && wpush_reg)
        else $error("warning window pushed without warning status");

endmodule
